// File: rtl/avg_pool_2x2_multichannel_top_assert.svh
// Assertion macros shared by the average pooling RTL.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef AVG_POOL_2X2_MULTICHANNEL_TOP_ASSERT_SVH
`define AVG_POOL_2X2_MULTICHANNEL_TOP_ASSERT_SVH

// property holds whenever reset is not asserted
`define AP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define AP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/apool_pkg.sv
// Package for the 2x2 average pooling block: default sizes and the lane control word.
// No dependencies.
`default_nettype none

package apool_pkg;

  localparam int Channels    = 6;
  localparam int ImgWidth    = 28;
  localparam int ImgHeight   = 28;
  localparam int FeatureBits = 16;

  // per-pixel control shared by all lanes
  typedef struct packed {
    logic load;     // word accepted: write row buffer, fetch top value
    logic advance;  // stage 1 moves on: shift window column
  } lane_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/apool_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on an address collision. No dependencies.
`default_nettype none

module apool_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 28
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/apool_lane.sv
// One channel lane: previous-row buffer, window column registers and the averager.
// Depends on apool_pkg and apool_ram.
`default_nettype none

module apool_lane import apool_pkg::*; #(
  parameter int IMG_WIDTH    = ImgWidth,
  parameter int FEATURE_BITS = FeatureBits
) (
  input  wire logic                              clk_i,
  input  wire lane_ctrl_t                        ctrl_i,
  input  wire logic        [$clog2(IMG_WIDTH)-1:0] col_i,
  input  wire logic signed [FEATURE_BITS-1:0]    pix_i,
  output logic signed      [FEATURE_BITS-1:0]    avg_o
);

  localparam int SumW = FEATURE_BITS + 2;

  logic signed [FEATURE_BITS-1:0] top_w;
  logic signed [FEATURE_BITS-1:0] pix_q;
  logic signed [FEATURE_BITS-1:0] left_top_q;
  logic signed [FEATURE_BITS-1:0] left_bot_q;
  logic signed [SumW-1:0]         sum_w;
  logic signed [SumW-1:0]         adj_w;
  logic signed [SumW-1:0]         shr_w;

  // row buffer: read-first, so top_w is the value from the row above
  apool_ram #(
    .WIDTH(FEATURE_BITS),
    .DEPTH(IMG_WIDTH)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.load),
    .waddr_i(col_i),
    .wdata_i(pix_i),
    .re_i   (ctrl_i.load),
    .raddr_i(col_i),
    .rdata_o(top_w)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pix_q <= pix_i;
    end
    if (ctrl_i.advance) begin
      left_top_q <= top_w;
      left_bot_q <= pix_q;
    end
  end

  always_comb begin
    sum_w = {{2{left_top_q[FEATURE_BITS-1]}}, left_top_q}
          + {{2{left_bot_q[FEATURE_BITS-1]}}, left_bot_q}
          + {{2{top_w[FEATURE_BITS-1]}}, top_w}
          + {{2{pix_q[FEATURE_BITS-1]}}, pix_q};
    // bias negative sums by 3 so the shift truncates toward zero
    adj_w = sum_w + {{(SumW-2){1'b0}}, sum_w[SumW-1], sum_w[SumW-1]};
    shr_w = adj_w >>> 2;
  end

  assign avg_o = shr_w[FEATURE_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/avg_pool_2x2_multichannel_top.sv
// 2x2 stride-2 average pooling over six channels, one lane per channel.
// A closing pixel is registered into stage 1 on acceptance; its average enters the output word when stage 1 advances.
// Throughput: one pixel per cycle unless output stalls; set by each lane's row buffer, read and written once a cycle.
// Output stall backs up through the single stage-1 register into in_stall_o.
// Reset clears row/column counters and valid flags; row buffers are not cleared.
`default_nettype none

module avg_pool_2x2_multichannel_top import apool_pkg::*; #(
  parameter int IMG_WIDTH    = ImgWidth,
  parameter int IMG_HEIGHT   = ImgHeight,
  parameter int FEATURE_BITS = FeatureBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [FEATURE_BITS-1:0] ch0_in_i,
  input  wire logic signed [FEATURE_BITS-1:0] ch1_in_i,
  input  wire logic signed [FEATURE_BITS-1:0] ch2_in_i,
  input  wire logic signed [FEATURE_BITS-1:0] ch3_in_i,
  input  wire logic signed [FEATURE_BITS-1:0] ch4_in_i,
  input  wire logic signed [FEATURE_BITS-1:0] ch5_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed      [FEATURE_BITS-1:0] ch0_avg_o,
  output logic signed      [FEATURE_BITS-1:0] ch1_avg_o,
  output logic signed      [FEATURE_BITS-1:0] ch2_avg_o,
  output logic signed      [FEATURE_BITS-1:0] ch3_avg_o,
  output logic signed      [FEATURE_BITS-1:0] ch4_avg_o,
  output logic signed      [FEATURE_BITS-1:0] ch5_avg_o,
  output logic                                frame_last_o
);

`include "avg_pool_2x2_multichannel_top_assert.svh"

  localparam int ColW    = $clog2(IMG_WIDTH);
  localparam int RowW    = $clog2(IMG_HEIGHT);
  localparam int LastCol = IMG_WIDTH - (IMG_WIDTH % 2) - 1;
  localparam int LastRow = IMG_HEIGHT - (IMG_HEIGHT % 2) - 1;

  logic                           accept_w;
  logic                           s1_adv_w;
  lane_ctrl_t                     ctrl_w;
  logic [ColW-1:0]                col_q;
  logic [RowW-1:0]                row_q;
  logic                           s1_valid_q;
  logic                           s1_emit_q;
  logic                           s1_last_q;
  logic                           out_valid_q;
  logic                           out_last_q;
  logic signed [FEATURE_BITS-1:0] pix_w   [Channels];
  logic signed [FEATURE_BITS-1:0] lane_w  [Channels];
  logic signed [FEATURE_BITS-1:0] avg_q   [Channels];

  assign pix_w[0] = ch0_in_i;
  assign pix_w[1] = ch1_in_i;
  assign pix_w[2] = ch2_in_i;
  assign pix_w[3] = ch3_in_i;
  assign pix_w[4] = ch4_in_i;
  assign pix_w[5] = ch5_in_i;

  // stage 1 moves on when the output word is empty or being taken
  assign s1_adv_w   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv_w;
  assign accept_w   = in_valid_i && !in_stall_o;

  assign ctrl_w.load    = accept_w;
  assign ctrl_w.advance = s1_adv_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_w) begin
      if (col_q == ColW'(IMG_WIDTH - 1)) begin
        col_q <= '0;
        row_q <= (row_q == RowW'(IMG_HEIGHT - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_w) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv_w) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      s1_emit_q <= row_q[0] && col_q[0];
      s1_last_q <= (row_q == RowW'(LastRow)) && (col_q == ColW'(LastCol));
    end
  end

  for (genvar c = 0; c < Channels; c++) begin : g_lane
    apool_lane #(
      .IMG_WIDTH   (IMG_WIDTH),
      .FEATURE_BITS(FEATURE_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .ctrl_i(ctrl_w),
      .col_i (col_q),
      .pix_i (pix_w[c]),
      .avg_o (lane_w[c])
    );
  end

  // merge: lane averages and the frame flag into one output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv_w) begin
      out_valid_q <= s1_emit_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_w && s1_emit_q) begin
      avg_q      <= lane_w;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ch0_avg_o    = avg_q[0];
  assign ch1_avg_o    = avg_q[1];
  assign ch2_avg_o    = avg_q[2];
  assign ch3_avg_o    = avg_q[3];
  assign ch4_avg_o    = avg_q[4];
  assign ch5_avg_o    = avg_q[5];
  assign frame_last_o = out_last_q;

  `AP_ASSERT(a_col_range, clk_i, rst_ni, int'(col_q) < IMG_WIDTH, "column counter out of range")
  `AP_ASSERT(a_row_range, clk_i, rst_ni, int'(row_q) < IMG_HEIGHT, "row counter out of range")
  `AP_ASSERT(a_stall_busy, clk_i, rst_ni, !in_stall_o || (s1_valid_q && out_valid_q),
             "input stalled without a blocked output word")
  `AP_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv_w,
                  s1_valid_q && $stable(s1_emit_q) && $stable(s1_last_q),
                  "stage 1 word lost while blocked")

endmodule

`default_nettype wire

// File: bench/pool_window_checker.sv
// Checker for the 2x2 average pooling block: tracks the window state, predicts pooled words.
// Compares every accepted output word with the oldest prediction.
// Depends on apool_pkg for channel count and default sizes.
`timescale 1ns / 100ps

module pool_window_checker import apool_pkg::*; #(
  parameter int IMG_WIDTH    = ImgWidth,
  parameter int IMG_HEIGHT   = ImgHeight,
  parameter int FEATURE_BITS = FeatureBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [Channels-1:0][FEATURE_BITS-1:0] pixel_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [Channels-1:0][FEATURE_BITS-1:0] avg_i,
  input  logic                                 frame_last_i,
  output int                                   pending_o,
  output int                                   fails_o
);

  // odd sizes: the trailing row or column never closes a window
  localparam int LastRow = (IMG_HEIGHT / 2) * 2 - 1;
  localparam int LastCol = (IMG_WIDTH / 2) * 2 - 1;

  typedef logic signed [FEATURE_BITS-1:0] feat_t;

  typedef struct packed {
    logic [Channels-1:0][FEATURE_BITS-1:0] avg;
    logic                                  last;
  } pooled_t;

  feat_t   line_buf [Channels][IMG_WIDTH];
  feat_t   left_top [Channels];
  feat_t   left_bot [Channels];
  int      row_q;
  int      col_q;
  int      mismatches = 0;
  pooled_t pooled_q [$];

  task automatic note_mismatch(input string what);
    $display("%0t ERROR: %s", $time, what);
    mismatches++;
  endtask

  // one accepted pixel: update window and line buffer, queue a word if a window closes
  task automatic pool_pixel(input logic [Channels-1:0][FEATURE_BITS-1:0] pix);
    pooled_t res;
    feat_t   top;
    feat_t   cur;
    int      sum;
    int      quot;
    res.last = (row_q == LastRow) && (col_q == LastCol);
    for (int c = 0; c < Channels; c++) begin
      cur  = pix[c];
      top  = line_buf[c][col_q];
      sum  = int'(left_top[c]) + int'(left_bot[c]) + int'(top) + int'(cur);
      quot = sum / 4;  // truncates toward zero
      res.avg[c]         = quot[FEATURE_BITS-1:0];
      left_top[c]        = top;
      left_bot[c]        = cur;
      line_buf[c][col_q] = cur;
    end
    if ((row_q % 2 == 1) && (col_q % 2 == 1)) pooled_q.push_back(res);
    col_q++;
    if (col_q >= IMG_WIDTH) begin
      col_q = 0;
      row_q++;
      if (row_q >= IMG_HEIGHT) row_q = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t exp_w;
    if (!rst_ni) begin
      row_q = 0;
      col_q = 0;
      pooled_q.delete();
      pending_o <= 0;
      fails_o   <= mismatches;
    end else begin
      // output first: a pixel accepted now cannot show up at this edge
      if (out_valid_i && !out_stall_i) begin
        if (pooled_q.size() == 0) begin
          note_mismatch("output word with nothing pending");
        end else begin
          exp_w = pooled_q.pop_front();
          for (int c = 0; c < Channels; c++) begin
            if (avg_i[c] !== exp_w.avg[c])
              note_mismatch($sformatf("ch%0d_avg expected %0d got %0d", c,
                                      $signed(exp_w.avg[c]), $signed(avg_i[c])));
          end
          if (frame_last_i !== exp_w.last)
            note_mismatch($sformatf("frame_last expected %0b got %0b",
                                    exp_w.last, frame_last_i));
        end
      end
      if (in_valid_i && !in_stall_i) pool_pixel(pixel_i);
      pending_o <= pooled_q.size();
      fails_o   <= mismatches;
    end
  end

endmodule

// File: bench/tb_avg_pool_2x2_multichannel_top.sv
// Testbench top for avg_pool_2x2_multichannel_top: drives pixel words, random output stalls.
// Depends on apool_pkg, the block RTL and pool_window_checker for prediction and compare.
`timescale 1ns / 100ps

module tb_avg_pool_2x2_multichannel_top;
  import apool_pkg::*;

  localparam int DirectedWords = 24;
  // random words after the directed ones
  localparam int RandomWords   = 426;
  localparam int DrainCycles   = 8;

  localparam logic [FeatureBits-1:0] FeatMax = {1'b0, {(FeatureBits-1){1'b1}}};
  localparam logic [FeatureBits-1:0] FeatMin = {1'b1, {(FeatureBits-1){1'b0}}};

  logic                                 clk;
  logic                                 rst_n     = 1'b0;
  logic                                 in_valid  = 1'b0;
  logic                                 out_stall = 1'b0;
  logic [Channels-1:0][FeatureBits-1:0] pix_q     = '0;

  wire                                  in_stall;
  wire                                  out_valid;
  wire                                  frame_last;
  wire  [Channels-1:0][FeatureBits-1:0] avg_w;

  int pending;
  int fails;
  int in_calm  = 0;
  int out_calm = 0;

  avg_pool_2x2_multichannel_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .ch0_in_i     (pix_q[0]),
    .ch1_in_i     (pix_q[1]),
    .ch2_in_i     (pix_q[2]),
    .ch3_in_i     (pix_q[3]),
    .ch4_in_i     (pix_q[4]),
    .ch5_in_i     (pix_q[5]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .ch0_avg_o    (avg_w[0]),
    .ch1_avg_o    (avg_w[1]),
    .ch2_avg_o    (avg_w[2]),
    .ch3_avg_o    (avg_w[3]),
    .ch4_avg_o    (avg_w[4]),
    .ch5_avg_o    (avg_w[5]),
    .frame_last_o (frame_last)
  );

  pool_window_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_i      (pix_q),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .avg_i        (avg_w),
    .frame_last_i (frame_last),
    .pending_o    (pending),
    .fails_o      (fails)
  );

  // draw a random wait, with occasional calm stretches of back-to-back words
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 15);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL avg_pool_2x2_multichannel_top");
    $finish;
  end

  // pixel word source
  initial begin
    logic [Channels-1:0][FeatureBits-1:0] w;
    int gap;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < DirectedWords + RandomWords; n++) begin
      gap = draw_wait(in_calm);
      for (int c = 0; c < Channels; c++) begin
        if (n < DirectedWords) begin
          case (n % 6)
            0:       w[c] = FeatMax;
            1:       w[c] = FeatMin;
            2:       w[c] = (c % 2 == 1) ? FeatMax : FeatMin;
            3:       w[c] = '1;
            4:       w[c] = FeatureBits'(1 << ((n + c) % FeatureBits));
            default: w[c] = FeatureBits'(~(1 << ((n + c) % FeatureBits)));
          endcase
        end else begin
          // bias toward extremes and small values around zero (truncation)
          case ($urandom_range(0, 9))
            0:       w[c] = FeatMax;
            1:       w[c] = FeatMin;
            2:       w[c] = '0;
            3:       w[c] = '1;
            4:       w[c] = FeatureBits'($urandom_range(0, 6) - 3);
            default: w[c] = FeatureBits'($urandom);
          endcase
        end
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      pix_q    <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0) begin
      $display("PASS avg_pool_2x2_multichannel_top");
    end else begin
      $display("FAIL avg_pool_2x2_multichannel_top");
    end
    $finish;
  end

  // output side: stall a random number of cycles before taking each word
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      hold = draw_wait(out_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule

// File: avg_pool_2x2_multichannel_top.f
+incdir+rtl
rtl/apool_pkg.sv
rtl/apool_ram.sv
rtl/apool_lane.sv
rtl/avg_pool_2x2_multichannel_top.sv
bench/pool_window_checker.sv
bench/tb_avg_pool_2x2_multichannel_top.sv
